// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the row fir convolver
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// shared types and constants of the row fir convolver
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int COEF_W    = 16;
    localparam int NUM_COEFS = 7;
    localparam int TAP_W     = 3;

    // job classification handed from front to back
    typedef struct packed {
        logic first;   // a result for the pixel behind the current one is due
        logic ends;    // the pixel closes its row
        logic img;     // the pixel closes the image
    } t_job_ctl;

    // flags travelling with a result beat
    typedef struct packed {
        logic saturated;
        logic row_end;
        logic image_end;
        logic last_of_run;
    } t_res_ctl;

endpackage

// ===== sv/rfc_queue.sv =====
// ----------------------------------------------------------------------------
// rfc_queue
// two-entry job queue between the front and the back of the convolver
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfc_queue import rfc_pkg::*; #(
    parameter int WIDTH = 112
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  t_job_ctl         i_ctl,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output t_job_ctl         o_ctl,
    input  logic             i_pop
);

    logic [WIDTH-1:0] r_data [2];
    t_job_ctl         r_ctl  [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rd];
    assign o_ctl   = r_ctl[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
            r_ctl[r_wr]  <= i_ctl;
        end
    end

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, i_push && o_full, "job pushed into full queue")
    `ASSERT_NEVER(a_queue_underflow, i_clk, i_rst_n, i_pop && !o_valid, "job popped from empty queue")

endmodule

// ===== sv/rfc_front.sv =====
// ----------------------------------------------------------------------------
// rfc_front
// pixel intake: keeps the row window and classifies each pixel into a job
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfc_front import rfc_pkg::*; #(
    parameter int MAX_TAPS    = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_last_row,
    input  logic                            i_last_img,
    output logic                            o_push,
    input  logic                            i_full,
    output logic [MAX_TAPS*SAMPLE_BITS-1:0] o_pix,
    output t_job_ctl                        o_ctl
);

    localparam int WIN_D = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;

    logic [WIN_D*SAMPLE_BITS-1:0] r_win, n_win;
    logic                         r_started;
    logic                         accept;
    logic                         ends;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign ends    = i_last_row || i_last_img;
    assign o_push  = accept && (r_started || ends);

    assign o_ctl.first = r_started;
    assign o_ctl.ends  = ends;
    assign o_ctl.img   = i_last_img;

    // slot 0 is the new pixel, slot j+1 the pixel j+1 behind it
    always_comb begin
        o_pix = '0;
        o_pix[SAMPLE_BITS-1:0] = i_sample;
        for (int j = 0; j < MAX_TAPS - 1; j++) begin
            o_pix[(j+1)*SAMPLE_BITS +: SAMPLE_BITS] = r_win[j*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    always_comb begin
        n_win = r_win;
        n_win[SAMPLE_BITS-1:0] = i_sample;
        for (int j = 1; j < WIN_D; j++) begin
            n_win[j*SAMPLE_BITS +: SAMPLE_BITS] = r_win[(j-1)*SAMPLE_BITS +: SAMPLE_BITS];
        end
        if (ends) begin
            n_win = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_started <= 1'b0;
        end else if (accept) begin
            r_win     <= n_win;
            r_started <= !ends;
        end
    end

    `ASSERT_CLK(a_row_end_clears, i_clk, i_rst_n, accept && ends |=> !r_started && (r_win == '0), "row end left window state")

endmodule

// ===== sv/rfc_back.sv =====
// ----------------------------------------------------------------------------
// rfc_back
// filter datapath: multiply, add, round, saturate and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfc_back import rfc_pkg::*; #(
    parameter int MAX_TAPS    = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [MAX_TAPS*SAMPLE_BITS-1:0] i_pix,
    input  t_job_ctl                        i_ctl,
    output logic                            o_pop,
    input  logic [NUM_COEFS*COEF_W-1:0]     i_coef,
    input  logic [TAP_W-1:0]                i_tap_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [SAMPLE_BITS-1:0]   o_filtered,
    output t_res_ctl                        o_res
);

    localparam int FRAC_BITS = 14;
    localparam int PROD_W    = SAMPLE_BITS + COEF_W;
    localparam int SUM_W     = PROD_W + 3;
    localparam int HALF      = (MAX_TAPS + 1) / 2;

    localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI  =
        {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO  =
        {{(SUM_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic                          second;
    logic                          issue;
    logic                          s1_ready, s2_ready, out_ready;
    logic                          r_s1_valid, r_s2_valid, r_o_valid;
    t_res_ctl                      s1_res, r_s1_res, r_s2_res, r_o_res;
    logic signed [SAMPLE_BITS-1:0] op   [MAX_TAPS];
    logic signed [PROD_W-1:0]      prod [MAX_TAPS];
    logic signed [PROD_W-1:0]      r_prod [MAX_TAPS];
    logic signed [SUM_W-1:0]       n_sum_a, n_sum_b, r_sum_a, r_sum_b;
    logic signed [SUM_W-1:0]       total, shifted;
    logic                          sat_hi, sat_lo;
    logic signed [SAMPLE_BITS-1:0] r_filtered;

    // handshake chain through the stages
    assign out_ready = !r_o_valid || i_ready;
    assign s2_ready  = !r_s2_valid || out_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign issue     = i_valid && s1_ready;

    // second result: row-closing beat, pixel one ahead is padding
    assign second = (r_phase == PH_SECOND) || !i_ctl.first;
    assign o_pop  = issue && (second || !i_ctl.ends);

    assign s1_res.saturated   = 1'b0;
    assign s1_res.row_end     = second;
    assign s1_res.image_end   = second && i_ctl.img;
    assign s1_res.last_of_run = second || !i_ctl.ends;

    always_comb begin
        n_phase = r_phase;
        if (issue) begin
            n_phase = (!second && i_ctl.ends) ? PH_SECOND : PH_FIRST;
        end
    end

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
        logic signed [COEF_W-1:0] coef_k;

        assign coef_k = i_coef[k*COEF_W +: COEF_W];

        if (k == 0) begin : g_ahead
            assign op[k] = second ? '0 : i_pix[SAMPLE_BITS-1:0];
        end else begin : g_behind
            assign op[k] = second ? i_pix[(k-1)*SAMPLE_BITS +: SAMPLE_BITS]
                                  : i_pix[k*SAMPLE_BITS +: SAMPLE_BITS];
        end

        assign prod[k] = op[k] * coef_k;

        always_ff @(posedge i_clk) begin
            if (issue) begin
                r_prod[k] <= (TAP_W'(k) < i_tap_count) ? prod[k] : '0;
            end
        end
    end

    always_comb begin
        n_sum_a = '0;
        n_sum_b = '0;
        for (int k = 0; k < HALF; k++) begin
            n_sum_a = n_sum_a + SUM_W'(r_prod[k]);
        end
        for (int k = HALF; k < MAX_TAPS; k++) begin
            n_sum_b = n_sum_b + SUM_W'(r_prod[k]);
        end
    end

    assign total   = r_sum_a + r_sum_b + ROUND_C;
    assign shifted = total >>> FRAC_BITS;
    assign sat_hi  = shifted > SAT_HI;
    assign sat_lo  = shifted < SAT_LO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (s1_ready) begin
                r_s1_valid <= issue;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_res <= s1_res;
        end
        if (r_s1_valid && s2_ready) begin
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_s2_res <= r_s1_res;
        end
        if (r_s2_valid && out_ready) begin
            priority if (sat_hi) begin
                r_filtered <= SAT_HI[SAMPLE_BITS-1:0];
            end else if (sat_lo) begin
                r_filtered <= SAT_LO[SAMPLE_BITS-1:0];
            end else begin
                r_filtered <= shifted[SAMPLE_BITS-1:0];
            end
            r_o_res <= '{saturated:   sat_hi || sat_lo,
                         row_end:     r_s2_res.row_end,
                         image_end:   r_s2_res.image_end,
                         last_of_run: r_s2_res.last_of_run};
        end
    end

    assign o_valid    = r_o_valid;
    assign o_filtered = r_filtered;
    assign o_res      = r_o_res;

    `ASSERT_CLK(a_second_needs_row_end, i_clk, i_rst_n, (r_phase == PH_SECOND) |-> i_valid && i_ctl.ends && i_ctl.first, "second result without a row-closing job")
    `ASSERT_CLK(a_row_end_is_last, i_clk, i_rst_n, r_o_valid && r_o_res.row_end |-> r_o_res.last_of_run, "row end beat not last of its run")

endmodule

// ===== sv/row_fir_convolver_top.sv =====
// ----------------------------------------------------------------------------
// row_fir_convolver_top
// horizontal fir filter over a row-ordered pixel stream with apb tap registers
// ----------------------------------------------------------------------------
// a pixel beat passes the job queue and the product, sum and output registers to its first result
// beat, a second row-closing beat after it; throughput: one pixel per cycle when not stalled;
// the two-entry job queue absorbs a row-closing job's second multiplier issue and output stalls
// reset: synchronous active low; clears window, queue, pipeline valids
// and loads tap weights (unity on tap 1, the pixel the result is for) and a tap count of three

module row_fir_convolver_top import rfc_pkg::*; #(
    parameter int MAX_TAPS    = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample
    input  logic                                s_axis_tlast,   // last_in_row
    input  logic                                s_axis_tuser,   // last_in_image
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // filtered
    output logic                                m_axis_tlast,   // row_end
    output logic [2:0]                          m_axis_tuser,   // saturated, image_end, last_of_run
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PIX_W  = MAX_TAPS * SAMPLE_BITS;

    localparam logic [2:0]              REG_COEF_1      = 3'd1;
    localparam logic [2:0]              REG_TAP_COUNT   = 3'd7;
    localparam logic signed [COEF_W-1:0] COEF_UNITY     = 16'sd16384;
    localparam logic [TAP_W-1:0]        TAP_COUNT_RESET = 3'd3;

    logic signed [COEF_W-1:0]       r_coef [NUM_COEFS];
    logic [TAP_W-1:0]               r_tap_count;
    logic [NUM_COEFS*COEF_W-1:0]    coef_bus;
    logic                           cfg_wr;
    logic [2:0]                     cfg_idx;

    logic                           f_push, q_full, q_valid, q_pop;
    logic [PIX_W-1:0]               f_pix, q_pix;
    t_job_ctl                       f_ctl, q_ctl;
    logic signed [SAMPLE_BITS-1:0]  b_filtered;
    t_res_ctl                       b_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[REG_COEF_1] <= COEF_UNITY;
            r_tap_count        <= TAP_COUNT_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx == REG_TAP_COUNT) begin
                r_tap_count <= pwdata[TAP_W-1:0];
            end else begin
                r_coef[cfg_idx] <= pwdata[COEF_W-1:0];
            end
        end
    end

    always_comb begin
        if (cfg_idx == REG_TAP_COUNT) begin
            prdata = 32'(r_tap_count);
        end else begin
            prdata = 32'(r_coef[cfg_idx]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_COEFS; i++) begin
            coef_bus[i*COEF_W +: COEF_W] = r_coef[i];
        end
    end

    rfc_front #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_last_row (s_axis_tlast),
        .i_last_img (s_axis_tuser),
        .o_push     (f_push),
        .i_full     (q_full),
        .o_pix      (f_pix),
        .o_ctl      (f_ctl)
    );

    rfc_queue #(
        .WIDTH (PIX_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_pix),
        .i_ctl   (f_ctl),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_pix),
        .o_ctl   (q_ctl),
        .i_pop   (q_pop)
    );

    rfc_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_pix       (q_pix),
        .i_ctl       (q_ctl),
        .o_pop       (q_pop),
        .i_coef      (coef_bus),
        .i_tap_count (r_tap_count),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_filtered  (b_filtered),
        .o_res       (b_res)
    );

    assign m_axis_tdata    = DATA_W'($unsigned(b_filtered));
    assign m_axis_tlast    = b_res.row_end;
    assign m_axis_tuser[0] = b_res.saturated;
    assign m_axis_tuser[1] = b_res.image_end;
    assign m_axis_tuser[2] = b_res.last_of_run;

endmodule
